### hdl/mdio_mm_pkg.sv
// Shared constants and types for the MDIO management master.
`default_nettype none

package mdio_mm_pkg;

  // Frame layout
  localparam int unsigned PREAMBLE_BITS    = 32;
  localparam int unsigned HEADER_BITS      = 14;
  localparam int unsigned READ_SAMPLES     = 17;
  localparam int unsigned WRITE_FRAME_BITS = 32;

  localparam int unsigned BIT_IDX_W = 7;
  localparam int unsigned DIV_W     = 8;
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned FRAME_W   = 32;

  typedef logic [BIT_IDX_W-1:0] bit_idx_t;
  typedef logic [DIV_W-1:0]     div_t;
  typedef logic [DATA_W-1:0]    data_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [FRAME_W-1:0]   frame_t;
  typedef logic [1:0]           cmd_t;

  // Command codes; anything else counts as a tick
  localparam cmd_t CMD_TICK  = 2'd0;
  localparam cmd_t CMD_READ  = 2'd1;
  localparam cmd_t CMD_WRITE = 2'd2;

  // Frame field codes
  localparam logic [1:0] FR_ST       = 2'b01;
  localparam logic [1:0] FR_OP_READ  = 2'b10;
  localparam logic [1:0] FR_OP_WRITE = 2'b01;
  localparam logic [1:0] FR_TA       = 2'b10;

  localparam div_t     DIV_RESET    = 8'd5;
  localparam bit_idx_t PREAMBLE_END = bit_idx_t'(PREAMBLE_BITS);
  localparam bit_idx_t RELEASE_START = bit_idx_t'(PREAMBLE_BITS + HEADER_BITS);
  localparam bit_idx_t TOTAL_READ   = bit_idx_t'(PREAMBLE_BITS + HEADER_BITS + READ_SAMPLES);
  localparam bit_idx_t TOTAL_WRITE  = bit_idx_t'(PREAMBLE_BITS + WRITE_FRAME_BITS);

  typedef struct packed {
    logic  mdc_level;
    logic  mdio_out;
    logic  mdio_drive;
    logic  busy_res;
    logic  read_done;
    data_t read_data;
  } result_t;

endpackage

`default_nettype wire

### hdl/mdio_mm_if.sv
// Valid/ready channel interfaces for the MDIO management master.
`default_nettype none

interface mdio_mm_in_if;
  logic                 valid;
  logic                 ready;
  mdio_mm_pkg::cmd_t    cmd;
  mdio_mm_pkg::addr_t   phy_addr;
  mdio_mm_pkg::addr_t   reg_addr;
  mdio_mm_pkg::data_t   write_data;
  logic                 mdio_in;

  modport source (output valid, cmd, phy_addr, reg_addr, write_data, mdio_in,
                  input ready);
  modport sink   (input valid, cmd, phy_addr, reg_addr, write_data, mdio_in,
                  output ready);
endinterface

interface mdio_mm_out_if;
  logic                 valid;
  logic                 ready;
  logic                 mdc_level;
  logic                 mdio_out;
  logic                 mdio_drive;
  logic                 busy_res;
  logic                 read_done;
  mdio_mm_pkg::data_t   read_data;

  modport source (output valid, mdc_level, mdio_out, mdio_drive, busy_res, read_done,
                  read_data, input ready);
  modport sink   (input valid, mdc_level, mdio_out, mdio_drive, busy_res, read_done,
                  read_data, output ready);
endinterface

`default_nettype wire

### hdl/mdio_management_master.sv
// Clause 22 MDIO management master: bit sequencer, divider and result register.
`default_nettype none

// Clause 22 management bus master. Every input beat is one step of the block:
// a tick (cmd 0, or unused code 3) advances the MDC divider if busy; a start read
// (cmd 1) or start write (cmd 2) loads a frame while idle and is treated as a
// tick while busy. MDC toggles every cfg_wdata-programmed clock_divider ticks
// (0 acts as 1; reset value 5). A transaction drives 32 preamble ones, then the
// frame MSB first, each bit set while MDC is low. A write sends all 32 frame
// bits; a read sends 14 header bits, releases MDIO (mdio_drive low), takes 17
// samples of mdio_in, one after each falling edge, keeps the last 16 samples in
// read_data, with read_done high on that one beat. Each input beat yields
// exactly one output beat showing the state after that beat. Throughput is one
// beat per clock: the sequencer update is a single pass from the current state
// and the input beat into the state registers and a one-deep result register,
// and the input stays ready while that register is empty or being drained, so
// a stalled output costs nothing until the next beat needs the slot. Output valid
// rises in the cycle after input acceptance. clock_divider must only
// be written while no beat is outstanding.
module mdio_management_master (
  input  wire                       clk,
  input  wire                       rst_n,
  mdio_mm_in_if.sink                in_bus,
  mdio_mm_out_if.source             out_bus,
  input  wire                       cfg_we,
  input  wire mdio_mm_pkg::div_t    cfg_wdata
);

  // Sequencer state
  mdio_mm_pkg::bit_idx_t bit_idx_r,  bit_idx_nxt;
  logic                  clk_high_r, clk_high_nxt;
  mdio_mm_pkg::div_t     div_cnt_r,  div_cnt_nxt;
  mdio_mm_pkg::frame_t   frame_r,    frame_nxt;
  mdio_mm_pkg::data_t    cap_r,      cap_nxt;
  logic                  is_read_r,  is_read_nxt;
  logic                  active_r,   active_nxt;
  logic                  line_r,     line_nxt;
  mdio_mm_pkg::data_t    held_r,     held_nxt;
  mdio_mm_pkg::div_t     div_r;

  // Result register
  logic                  out_valid_r;
  mdio_mm_pkg::result_t  out_item_r;
  mdio_mm_pkg::result_t  result;

  logic                  in_fire;
  logic                  done;
  logic                  in_release;
  logic                  start;
  mdio_mm_pkg::div_t     div_eff;
  mdio_mm_pkg::div_t     div_inc;
  mdio_mm_pkg::bit_idx_t bit_inc;
  mdio_mm_pkg::bit_idx_t total;

  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign in_fire      = in_bus.valid && in_bus.ready;

  assign div_eff    = (div_r == '0) ? mdio_mm_pkg::div_t'(1) : div_r;
  assign in_release = active_r && is_read_r && (bit_idx_r >= mdio_mm_pkg::RELEASE_START);
  assign total      = is_read_r ? mdio_mm_pkg::TOTAL_READ : mdio_mm_pkg::TOTAL_WRITE;
  assign div_inc    = div_cnt_r + mdio_mm_pkg::div_t'(1);
  assign bit_inc    = bit_idx_r + mdio_mm_pkg::bit_idx_t'(1);
  assign start      = !active_r && ((in_bus.cmd == mdio_mm_pkg::CMD_READ) ||
                                    (in_bus.cmd == mdio_mm_pkg::CMD_WRITE));

  // Sequencer next state
  always_comb begin
    bit_idx_nxt  = bit_idx_r;
    clk_high_nxt = clk_high_r;
    div_cnt_nxt  = div_cnt_r;
    frame_nxt    = frame_r;
    cap_nxt      = cap_r;
    is_read_nxt  = is_read_r;
    active_nxt   = active_r;
    line_nxt     = line_r;
    held_nxt     = held_r;
    done         = 1'b0;
    if (in_fire) begin
      if (start) begin
        is_read_nxt = (in_bus.cmd == mdio_mm_pkg::CMD_READ);
        if (in_bus.cmd == mdio_mm_pkg::CMD_READ) begin
          frame_nxt = {mdio_mm_pkg::FR_ST, mdio_mm_pkg::FR_OP_READ, in_bus.phy_addr,
                       in_bus.reg_addr, 18'd0};
        end else begin
          frame_nxt = {mdio_mm_pkg::FR_ST, mdio_mm_pkg::FR_OP_WRITE, in_bus.phy_addr,
                       in_bus.reg_addr, mdio_mm_pkg::FR_TA, in_bus.write_data};
        end
        active_nxt   = 1'b1;
        bit_idx_nxt  = '0;
        clk_high_nxt = 1'b0;
        div_cnt_nxt  = '0;
        cap_nxt      = '0;
        line_nxt     = 1'b1;  // first preamble bit
      end else if (active_r) begin
        if (div_inc >= div_eff) begin
          div_cnt_nxt = '0;
          if (!clk_high_r) begin
            clk_high_nxt = 1'b1;
          end else begin
            // falling edge: sample, then move to the next bit
            clk_high_nxt = 1'b0;
            if (in_release) begin
              cap_nxt = {cap_r[mdio_mm_pkg::DATA_W-2:0], in_bus.mdio_in};
            end
            if (bit_inc >= total) begin
              if (is_read_r) begin
                held_nxt = cap_nxt;
                done     = 1'b1;
              end
              active_nxt  = 1'b0;
              bit_idx_nxt = '0;
              line_nxt    = 1'b1;
            end else begin
              bit_idx_nxt = bit_inc;
              if ((bit_inc < mdio_mm_pkg::PREAMBLE_END) ||
                  (is_read_r && (bit_inc >= mdio_mm_pkg::RELEASE_START))) begin
                line_nxt = 1'b1;
              end else begin
                line_nxt  = frame_r[mdio_mm_pkg::FRAME_W-1];
                frame_nxt = {frame_r[mdio_mm_pkg::FRAME_W-2:0], 1'b0};
              end
            end
          end
        end else begin
          div_cnt_nxt = div_inc;
        end
      end
    end
  end

  // Result for this beat: state after the update
  always_comb begin
    result.mdc_level  = clk_high_nxt;
    result.mdio_out   = line_nxt;
    result.mdio_drive = !(active_nxt && is_read_nxt &&
                          (bit_idx_nxt >= mdio_mm_pkg::RELEASE_START));
    result.busy_res   = active_nxt;
    result.read_done  = done;
    result.read_data  = held_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_idx_r  <= '0;
      clk_high_r <= 1'b0;
      div_cnt_r  <= '0;
      frame_r    <= '0;
      cap_r      <= '0;
      is_read_r  <= 1'b0;
      active_r   <= 1'b0;
      line_r     <= 1'b1;
      held_r     <= '0;
      div_r      <= mdio_mm_pkg::DIV_RESET;
    end else begin
      bit_idx_r  <= bit_idx_nxt;
      clk_high_r <= clk_high_nxt;
      div_cnt_r  <= div_cnt_nxt;
      frame_r    <= frame_nxt;
      cap_r      <= cap_nxt;
      is_read_r  <= is_read_nxt;
      active_r   <= active_nxt;
      line_r     <= line_nxt;
      held_r     <= held_nxt;
      if (cfg_we) begin
        div_r <= cfg_wdata;
      end
    end
  end

  // Output beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_item_r <= result;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.mdc_level  = out_item_r.mdc_level;
  assign out_bus.mdio_out   = out_item_r.mdio_out;
  assign out_bus.mdio_drive = out_item_r.mdio_drive;
  assign out_bus.busy_res   = out_item_r.busy_res;
  assign out_bus.read_done  = out_item_r.read_done;
  assign out_bus.read_data  = out_item_r.read_data;

`ifndef SYNTH
  // Bit counter never runs past the longest frame
  a_bit_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (bit_idx_r < mdio_mm_pkg::TOTAL_WRITE))
    else $error("bit index out of range");

  // Idle means MDC low, line high, counter parked
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (!clk_high_r && line_r && (bit_idx_r == '0)))
    else $error("idle state not clean");

  // Divider count stays below the half period while running
  a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (div_cnt_r < div_eff))
    else $error("divider count overrun");

  // A completed read ends the transaction on that beat
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.read_done) |-> (!out_item_r.busy_res && out_item_r.mdio_drive))
    else $error("read done while busy");
`endif

endmodule

`default_nettype wire

### test/tb.sv
`timescale 1ns / 100ps
// Testbench for the MDIO management master: directed and random beats vs a sequencer model.
module tb;
  import mdio_mm_pkg::*;

  // Unused command code; the block takes it as a tick.
  localparam cmd_t CMD_SPARE      = 2'd3;
  localparam int   IDLE_PCT       = 6;     // chance in percent of a sender gap before a beat or of a receiver stall
  localparam int   WATCHDOG_LIMIT = 2000;  // cycles with no beat on either side
  localparam int   ITEM_TARGET    = 750;   // input beats for the whole run

  // Level fed back on mdio_in while the block samples a read.
  typedef enum int {MDIO_LOW, MDIO_HIGH, MDIO_TOGGLE, MDIO_RANDOM} mdio_pattern_e;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  div_t cfg_wdata;

  mdio_mm_in_if  in_bus();
  mdio_mm_out_if out_bus();

  mdio_management_master u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .out_bus  (out_bus),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Sequencer model: our own copy of the MDC divider, bit counter and shifters.
  // Stepped once per accepted input beat; yields the bus snapshot the block
  // must report for that beat.
  // ---------------------------------------------------------------------------
  div_t     seq_divider  = DIV_RESET;
  bit_idx_t seq_bit      = '0;    // frame bits completed so far, preamble included
  logic     seq_mdc_high = 1'b0;
  div_t     seq_div_cnt  = '0;
  frame_t   seq_frame    = '0;    // bits left to send, MSB first
  data_t    seq_capture  = '0;    // read samples, shifted in at the bottom
  logic     seq_is_read  = 1'b0;
  logic     seq_active   = 1'b0;
  logic     seq_line     = 1'b1;
  data_t    seq_held     = '0;    // last completed read

  result_t  expected_snapshots[$];
  int       error_count = 0;
  int       beats_sent  = 0;
  bit       gaps_on     = 1'b1;
  bit       stall_on    = 1'b1;

  // MDIO is released once the read header is out.
  function automatic logic mdio_released();
    return seq_active && seq_is_read && (seq_bit >= RELEASE_START);
  endfunction

  // Put the level for the current bit on the line: preamble and the
  // released window read as 1, otherwise pop the next frame bit.
  function automatic void drive_next_bit();
    if (seq_bit < PREAMBLE_END || mdio_released()) begin
      seq_line = 1'b1;
    end else begin
      seq_line  = seq_frame[FRAME_W-1];
      seq_frame = seq_frame << 1;
    end
  endfunction

  function automatic result_t sequencer_step(cmd_t cmd, addr_t pa, addr_t ra, data_t wdat,
                                             logic sample);
    div_t     period;
    logic     sampling;
    logic     done;
    bit_idx_t frame_end;
    result_t  snap;
    done = 1'b0;
    if (!seq_active && (cmd == CMD_READ || cmd == CMD_WRITE)) begin
      // Start while idle: load only, no time passes on this beat.
      seq_is_read = (cmd == CMD_READ);
      if (seq_is_read) begin
        seq_frame = {FR_ST, FR_OP_READ, pa, ra, {(DATA_W + 2){1'b0}}};
      end else begin
        seq_frame = {FR_ST, FR_OP_WRITE, pa, ra, FR_TA, wdat};
      end
      seq_active   = 1'b1;
      seq_bit      = '0;
      seq_mdc_high = 1'b0;
      seq_div_cnt  = '0;
      seq_capture  = '0;
      drive_next_bit();
    end else if (seq_active) begin
      // Any other command while busy is a tick. Divider 0 acts as 1.
      period      = (seq_divider == '0) ? div_t'(1) : seq_divider;
      seq_div_cnt = seq_div_cnt + 1'b1;
      if (seq_div_cnt >= period) begin
        seq_div_cnt = '0;
        if (!seq_mdc_high) begin
          seq_mdc_high = 1'b1;
        end else begin
          // Falling edge: sample in the release window, then next bit.
          sampling     = mdio_released();
          seq_mdc_high = 1'b0;
          if (sampling) begin
            seq_capture = {seq_capture[DATA_W-2:0], sample};
          end
          seq_bit   = seq_bit + 1'b1;
          frame_end = seq_is_read ? TOTAL_READ : TOTAL_WRITE;
          if (seq_bit >= frame_end) begin
            if (seq_is_read) begin
              seq_held = seq_capture;
              done     = 1'b1;
            end
            seq_active = 1'b0;
            seq_bit    = '0;
            seq_line   = 1'b1;
          end else begin
            drive_next_bit();
          end
        end
      end
    end
    snap.mdc_level  = seq_mdc_high;
    snap.mdio_out   = seq_line;
    snap.mdio_drive = !mdio_released();
    snap.busy_res   = seq_active;
    snap.read_done  = done;
    snap.read_data  = seq_held;
    return snap;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Valid stays high from beat to beat unless a gap is drawn or a
  // drain is awaited, so valid gets at most one update per time step.
  // ---------------------------------------------------------------------------
  task automatic send_beat(cmd_t cmd, addr_t pa, addr_t ra, data_t wdat, logic sample);
    if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.cmd        <= cmd;
    in_bus.phy_addr   <= pa;
    in_bus.reg_addr   <= ra;
    in_bus.write_data <= wdat;
    in_bus.mdio_in    <= sample;
    do @(posedge clk); while (!in_bus.ready);
    expected_snapshots.push_back(sequencer_step(cmd, pa, ra, wdat, sample));
    beats_sent++;
  endtask

  // Hold the sender off until every outstanding beat has come back.
  task automatic wait_results();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (expected_snapshots.size() != 0);
  endtask

  // Divider is only touched with the block drained.
  task automatic set_divider(div_t value);
    wait_results();
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    seq_divider  = value;
  endtask

  function automatic logic pick_sample(mdio_pattern_e pattern);
    case (pattern)
      MDIO_LOW:    return 1'b0;
      MDIO_HIGH:   return 1'b1;
      MDIO_TOGGLE: return beats_sent[0];
      default:     return 1'($urandom_range(1, 0));
    endcase
  endfunction

  // Tick until the frame ends. With noise on, stray starts and the spare code
  // land mid-frame, and now and then the sender pauses for a full drain.
  task automatic run_frame(mdio_pattern_e pattern, bit noisy);
    cmd_t cmd;
    while (seq_active) begin
      cmd = CMD_TICK;
      if (noisy && $urandom_range(9) == 0) begin
        cmd = cmd_t'($urandom_range(3, 0));
      end
      if (noisy && $urandom_range(199) == 0) begin
        wait_results();
      end
      send_beat(cmd, addr_t'($urandom), addr_t'($urandom), data_t'($urandom),
                pick_sample(pattern));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stalls, and each beat checked against the oldest
  // expected snapshot.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_bus.ready <= !(stall_on && $urandom_range(99) < IDLE_PCT);
  end

  result_t observed;
  result_t wanted;

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      observed = {out_bus.mdc_level, out_bus.mdio_out, out_bus.mdio_drive,
                  out_bus.busy_res, out_bus.read_done, out_bus.read_data};
      if (expected_snapshots.size() == 0) begin
        $display("%0t: unexpected result beat, actual %p", $time, observed);
        error_count++;
      end else begin
        wanted = expected_snapshots.pop_front();
        if (observed !== wanted) begin
          $display("%0t: result mismatch, expected %p actual %p", $time, wanted, observed);
          error_count++;
        end
      end
    end
  end

  // Watchdog: too long with no beat moving on either side ends the run.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               expected_snapshots.size());
      $display("mdio_management_master: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Ticks and the spare code while idle change nothing.
  task automatic test_idle_ticks();
    send_beat(CMD_TICK,  '1, '1, '1, 1'b1);
    send_beat(CMD_SPARE, '0, '0, '0, 1'b0);
    send_beat(CMD_SPARE, '1, '1, '1, 1'b1);
    send_beat(CMD_TICK,  '0, '0, '0, 1'b0);
  endtask

  // Reset divider for the first full MDC clock of a write, then the rest of
  // the frame at divider 1. The switch lands right on a half-period boundary.
  task automatic test_reset_divider();
    send_beat(CMD_WRITE, '1, '0, '1, 1'b0);
    repeat (2 * DIV_RESET) send_beat(CMD_TICK, '0, '0, '0, 1'b0);
    while (seq_div_cnt != '0) begin
      send_beat(CMD_TICK, '0, '0, '0, 1'b0);
    end
    set_divider(div_t'(1));
    run_frame(MDIO_RANDOM, 1'b0);
  endtask

  // Field extremes and a toggling read-back at the fastest MDC.
  task automatic test_frame_extremes();
    set_divider(div_t'(1));
    send_beat(CMD_READ, '1, '1, '1, 1'b0);
    run_frame(MDIO_TOGGLE, 1'b0);
  endtask

  // Starts and the spare code while busy act as ticks; a start right after
  // a frame ends loads the next one.
  task automatic test_busy_starts();
    set_divider(div_t'(1));
    send_beat(CMD_WRITE, 5'h03, 5'h1C, 16'h1234, 1'b0);
    send_beat(CMD_READ,  '1, '1, '1, 1'b1);
    send_beat(CMD_WRITE, '0, '0, '0, 1'b0);
    send_beat(CMD_SPARE, '1, '1, '1, 1'b1);
    run_frame(MDIO_RANDOM, 1'b1);
    send_beat(CMD_READ, 5'h1D, 5'h1E, '0, 1'b1);
    run_frame(MDIO_RANDOM, 1'b1);
  endtask

  // Divider 0 runs like divider 1.
  task automatic test_divider_zero();
    set_divider(div_t'(0));
    send_beat(CMD_WRITE, 5'h02, 5'h11, 16'h5A5A, 1'b0);
    run_frame(MDIO_RANDOM, 1'b0);
  endtask

  // Random frames until the beat budget is used. The first frame runs with
  // no gaps or stalls at all.
  task automatic test_random_frames();
    bit quiet_frame;
    quiet_frame = 1'b1;
    set_divider(div_t'(1));
    while (beats_sent < ITEM_TARGET) begin
      gaps_on  = !quiet_frame;
      stall_on = !quiet_frame;
      // Occasional idle noise before the start.
      if ($urandom_range(99) < 15) begin
        send_beat($urandom_range(1, 0) ? CMD_TICK : CMD_SPARE, addr_t'($urandom),
                  addr_t'($urandom), data_t'($urandom), 1'($urandom_range(1, 0)));
      end
      send_beat($urandom_range(1, 0) ? CMD_READ : CMD_WRITE, addr_t'($urandom),
                addr_t'($urandom), data_t'($urandom), 1'($urandom_range(1, 0)));
      run_frame(MDIO_RANDOM, !quiet_frame);
      quiet_frame = 1'b0;
    end
    gaps_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  initial begin
    in_bus.valid      <= 1'b0;
    in_bus.cmd        <= CMD_TICK;
    in_bus.phy_addr   <= '0;
    in_bus.reg_addr   <= '0;
    in_bus.write_data <= '0;
    in_bus.mdio_in    <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= DIV_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_ticks();
    test_reset_divider();
    test_frame_extremes();
    test_busy_starts();
    test_divider_zero();
    test_random_frames();

    // Drain, then a few more clocks to catch any stray result beat.
    wait_results();
    repeat (4) @(posedge clk);
    if (error_count == 0 && expected_snapshots.size() == 0) begin
      $display("mdio_management_master: match");
    end else begin
      $display("mdio_management_master: mismatch");
    end
    $finish;
  end

endmodule
